@@ sv/max_heap_priority_queue_core_assert.svh @@
// Assertion macros for the max-heap priority queue core.
// Included by the top level; needs no package.
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MHPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mhpq assertion failed");

// Next-cycle implication, checked outside reset.
`define MHPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mhpq assertion failed");

`endif

@@ sv/mhpq_pkg.sv @@
// Shared constants, types and status codes for the max-heap priority queue.
// No dependencies.
package mhpq_pkg;

	localparam int CAPACITY   = 128;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = CNT_W + 1;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [CNT_W-1:0]             cnt_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [ADDR_W-1:0]            addr_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		data_t wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	typedef struct packed {
		logic [1:0] status;
		data_t      removed;
		cnt_t       count;
		data_t      top;
		logic       top_valid;
	} result_t;

endpackage

@@ sv/mhpq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mhpq_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/mhpq_ctrl.sv @@
// Sift sequencer: walks the heap through the RAM port, one level at a time.
// Depends on mhpq_pkg; drives an mhpq_ram through mem_req.
module mhpq_ctrl
	import mhpq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     operation,
	input  data_t    new_val,
	input  data_t    rd_data,
	output logic     busy,
	output mem_req_t mem_req,
	output logic     res_valid,
	output result_t  res
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_UP_RD   = 3'd1;
	localparam logic [2:0] S_UP_CMP  = 3'd2;
	localparam logic [2:0] S_DN_LOAD = 3'd3;
	localparam logic [2:0] S_DN_RDL  = 3'd4;
	localparam logic [2:0] S_DN_RDR  = 3'd5;
	localparam logic [2:0] S_DN_SEL  = 3'd6;
	localparam logic [2:0] S_FIN     = 3'd7;

	logic [2:0] state_q, state_d;
	cnt_t       cnt_q, cnt_d;
	cnt_t       lim_q, lim_d;
	idx_t       idx_q, idx_d;
	data_t      val_q, val_d;
	data_t      left_q, left_d;
	data_t      root_q;
	data_t      removed_q, removed_d;
	logic [1:0] status_q, status_d;

	idx_t  child_idx, parent_idx, lim_ext, cnt_ext;
	data_t best_val;
	idx_t  best_idx;

	// index is one-based, RAM address zero-based
	function automatic addr_t to_addr(input idx_t i);
		idx_t m;
		m = i - idx_t'(1);
		return m[ADDR_W-1:0];
	endfunction

	assign child_idx  = idx_q << 1;
	assign parent_idx = idx_q >> 1;
	assign lim_ext    = idx_t'(lim_q);
	assign cnt_ext    = idx_t'(cnt_q);

	// larger child, left on a tie
	always_comb begin
		if (rd_data > left_q) begin
			best_val = rd_data;
			best_idx = child_idx + idx_t'(1);
		end else begin
			best_val = left_q;
			best_idx = child_idx;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		lim_d     = lim_q;
		idx_d     = idx_q;
		val_d     = val_q;
		left_d    = left_q;
		removed_d = removed_q;
		status_d  = status_q;
		mem_req   = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					removed_d = '0;
					status_d  = ST_OK;
					if (operation == OP_INSERT) begin
						if (cnt_q == cnt_t'(CAPACITY)) begin
							status_d = ST_FULL;
							state_d  = S_FIN;
						end else begin
							cnt_d   = cnt_q + cnt_t'(1);
							idx_d   = cnt_ext + idx_t'(1);
							val_d   = new_val;
							state_d = S_UP_RD;
						end
					end else begin
						if (cnt_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_FIN;
						end else begin
							removed_d = root_q;
							cnt_d     = cnt_q - cnt_t'(1);
							if (cnt_q == cnt_t'(1)) begin
								state_d = S_FIN;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = to_addr(cnt_ext);
								lim_d         = cnt_q - cnt_t'(1);
								idx_d         = idx_t'(1);
								state_d       = S_DN_LOAD;
							end
						end
					end
				end
			end
			S_UP_RD: begin
				if (idx_q == idx_t'(1)) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = to_addr(idx_q);
					mem_req.wdata = val_q;
					state_d       = S_FIN;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = to_addr(parent_idx);
					state_d       = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = to_addr(idx_q);
				if (rd_data < val_q) begin
					mem_req.wdata = rd_data;
					idx_d         = parent_idx;
					state_d       = S_UP_RD;
				end else begin
					mem_req.wdata = val_q;
					state_d       = S_FIN;
				end
			end
			S_DN_LOAD: begin
				val_d   = rd_data;
				state_d = S_DN_RDL;
			end
			S_DN_RDL: begin
				if (child_idx > lim_ext) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = to_addr(idx_q);
					mem_req.wdata = val_q;
					state_d       = S_FIN;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = to_addr(child_idx);
					state_d       = S_DN_RDR;
				end
			end
			S_DN_RDR: begin
				left_d = rd_data;
				if (child_idx + idx_t'(1) <= lim_ext) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = to_addr(child_idx + idx_t'(1));
					state_d       = S_DN_SEL;
				end else begin
					mem_req.we    = 1'b1;
					mem_req.waddr = to_addr(idx_q);
					if (rd_data > val_q) begin
						mem_req.wdata = rd_data;
						idx_d         = child_idx;
						state_d       = S_DN_RDL;
					end else begin
						mem_req.wdata = val_q;
						state_d       = S_FIN;
					end
				end
			end
			S_DN_SEL: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = to_addr(idx_q);
				if (best_val > val_q) begin
					mem_req.wdata = best_val;
					idx_d         = best_idx;
					state_d       = S_DN_RDL;
				end else begin
					mem_req.wdata = val_q;
					state_d       = S_FIN;
				end
			end
			S_FIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// payload; root copy follows every write to the top slot
	always_ff @(posedge clk) begin
		lim_q     <= lim_d;
		idx_q     <= idx_d;
		val_q     <= val_d;
		left_q    <= left_d;
		removed_q <= removed_d;
		status_q  <= status_d;
		if (mem_req.we && (mem_req.waddr == '0)) begin
			root_q <= mem_req.wdata;
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign res_valid     = (state_q == S_FIN);
	assign res.status    = status_q;
	assign res.removed   = removed_q;
	assign res.count     = cnt_q;
	assign res.top_valid = (cnt_q != '0);
	assign res.top       = (cnt_q != '0) ? root_q : data_t'(0);

endmodule

@@ sv/max_heap_priority_queue_core.sv @@
// Top level of the max-heap priority queue: sequencer, heap RAM, result register.
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_ram and max_heap_priority_queue_core_assert.svh.
//
//  channel  | handshake        | fields
//  ---------+------------------+---------------------------------------------------
//  command  | start, busy      | operation, new_value
//  result   | done (one cycle) | status, removed_value, entry_count, top_value,
//           |                  | top_valid
//
// One item at a time. busy rises at the accepting edge and falls after FIN; done is high
// in the first cycle with busy low, which is also the earliest cycle for the next item.
// Insert: per level climbed, read the parent, then compare and write; then FIN.
// Remove: load the last entry, then per level descended read the left child, read the right
// child if present, compare and write; a final write, then FIN. Reset clears the entry count,
// sequencer state and done strobe; the RAM needs no clearing. The receiver cannot stall.
`include "max_heap_priority_queue_core_assert.svh"

module max_heap_priority_queue_core
	import mhpq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic signed [31:0] new_value,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic [7:0]         entry_count,
	output logic signed [31:0] top_value,
	output logic               top_valid
);

	mem_req_t mem_req;
	data_t    rd_data;
	data_t    new_val;
	logic     ctrl_busy;
	logic     res_valid;
	result_t  res;
	logic     done_q;
	result_t  res_q;

	// incoming value taken at the heap's width, sign preserved
	assign new_val = data_t'(new_value);

	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.new_val   (new_val),
		.rd_data   (rd_data),
		.busy      (ctrl_busy),
		.mem_req   (mem_req),
		.res_valid (res_valid),
		.res       (res)
	);

	mhpq_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_WIDTH),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rd_data)
	);

	// result register: one-cycle strobe, payload unreset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign busy          = ctrl_busy;
	assign done          = done_q;
	assign status        = res_q.status;
	assign removed_value = 32'($signed(res_q.removed));
	assign entry_count   = 8'(res_q.count);
	assign top_value     = 32'($signed(res_q.top));
	assign top_valid     = res_q.top_valid;

	// an accepted item always starts the sequencer
	`MHPQ_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// the sequencer never reads the slot it is writing in the same cycle
	`MHPQ_ASSERT_IMP(a_no_rw_clash, clk, arst_n, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr)
	// a result only follows work
	`MHPQ_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy))
	// failed operations hand back no value
	`MHPQ_ASSERT_IMP(a_fail_no_value, clk, arst_n, done && (status != ST_OK), removed_value == 32'sd0)

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for max_heap_priority_queue_core: insert and remove items
// driven through start/busy, results checked on done against a heap predictor.
// Depends on mhpq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
	import mhpq_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_WAIT  = 40;

	// One command item for the driver; gap is the idle time before it is offered.
	typedef struct {
		logic  op;
		data_t value;
		int    gap;
	} cmd_t;

	// One result item as the core presents it on done.
	typedef struct {
		logic [1:0] status;
		data_t      removed;
		logic [7:0] count;
		data_t      top;
		logic       top_valid;
	} heap_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               operation = OP_INSERT;
	logic signed [31:0] new_value = '0;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] removed_value;
	logic [7:0]         entry_count;
	logic signed [31:0] top_value;
	logic               top_valid;

	cmd_t         pending_cmds[$];
	heap_result_t awaited_results[$];

	// Predictor state: one-based mirror of the heap and its fill level.
	data_t heap_mirror [1:CAPACITY];
	int    mirror_count = 0;

	int   plan_count = 0;   // fill level as the stimulus planner sees it
	bit   gaps_on = 1'b1;   // sender idling allowed for newly planned items
	int   total_cmds = 0;
	int   n_accepted = 0;
	int   errors = 0;
	int   cycle_count = 0;
	logic taken = 1'b0;     // item accepted at the last rising edge

	max_heap_priority_queue_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.new_value    (new_value),
		.done         (done),
		.status       (status),
		.removed_value(removed_value),
		.entry_count  (entry_count),
		.top_value    (top_value),
		.top_valid    (top_valid)
	);

	always #6 clk = ~clk;

	// Applies one item to the mirror heap and returns the result it must produce.
	// Sift-up stops on equality; sift-down takes the left child on a tie and only
	// swaps when the child is strictly larger.
	function automatic heap_result_t heap_apply(logic op, data_t value);
		heap_result_t r;
		int           i;
		int           c;
		data_t        t;
		r.status    = ST_OK;
		r.removed   = '0;
		r.count     = '0;
		r.top       = '0;
		r.top_valid = 1'b0;
		if (op == OP_INSERT) begin
			if (mirror_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				mirror_count++;
				heap_mirror[mirror_count] = value;
				i = mirror_count;
				while (i > 1 && heap_mirror[i / 2] < heap_mirror[i]) begin
					t = heap_mirror[i / 2];
					heap_mirror[i / 2] = heap_mirror[i];
					heap_mirror[i] = t;
					i = i / 2;
				end
			end
		end else begin
			if (mirror_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.removed = heap_mirror[1];
				heap_mirror[1] = heap_mirror[mirror_count];
				mirror_count--;
				i = 1;
				while (2 * i <= mirror_count) begin
					c = 2 * i;
					if (c + 1 <= mirror_count && heap_mirror[c + 1] > heap_mirror[c])
						c++;
					if (heap_mirror[c] > heap_mirror[i]) begin
						t = heap_mirror[c];
						heap_mirror[c] = heap_mirror[i];
						heap_mirror[i] = t;
						i = c;
					end else begin
						break;
					end
				end
			end
		end
		r.count = 8'(mirror_count);
		if (mirror_count > 0) begin
			r.top       = heap_mirror[1];
			r.top_valid = 1'b1;
		end
		return r;
	endfunction

	// Queues one item; the planner tracks the fill level so phases can aim at
	// full and empty.
	task automatic plan(input logic op, input data_t value);
		cmd_t c;
		c.op    = op;
		c.value = value;
		c.gap   = (gaps_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 19)) : 0;
		pending_cmds.push_back(c);
		if (op == OP_INSERT && plan_count < CAPACITY)
			plan_count++;
		else if (op == OP_REMOVE && plan_count > 0)
			plan_count--;
	endtask

	// Mostly full-range values, with a share of small ones for duplicate keys
	// and a share of the extremes.
	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0, 1: begin
				case ($urandom_range(0, 3))
					0:       return data_t'(32'h7fff_ffff);
					1:       return data_t'(32'h8000_0000);
					2:       return data_t'(0);
					default: return data_t'(-1);
				endcase
			end
			2, 3, 4: return data_t'(int'($urandom_range(0, 16)) - 8);
			default: return data_t'($urandom);
		endcase
	endfunction

	task automatic plan_mixed(input int n, input int insert_pct);
		int k;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < insert_pct)
				plan(OP_INSERT, pick_value());
			else
				plan(OP_REMOVE, data_t'($urandom));
		end
	endtask

	// Driver: changes inputs on the falling edge only. start is held until the
	// item is taken, then the next item (or an idle cycle) follows. While idle
	// the payload ports carry noise that the core must ignore.
	always @(negedge clk) begin
		cmd_t c;
		if (arst_n) begin
			if (start && !taken) begin
				// still waiting for the core to take the current item
			end else if (pending_cmds.size() != 0 && pending_cmds[0].gap == 0) begin
				c = pending_cmds.pop_front();
				start     <= 1'b1;
				operation <= c.op;
				new_value <= c.value;
			end else begin
				if (pending_cmds.size() != 0)
					pending_cmds[0].gap--;
				start     <= 1'b0;
				operation <= logic'($urandom_range(0, 1));
				new_value <= $urandom;
			end
		end
	end

	// Monitor and acceptance, both on the rising edge. The result check comes
	// first so a done on the same edge as a new item pairs with the older one.
	always @(posedge clk) begin
		heap_result_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (awaited_results.size() == 0) begin
					$error("result on done with no item outstanding");
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						errors++;
					end
					if (removed_value !== want.removed) begin
						$error("removed_value: expected %0d, actual %0d",
							want.removed, removed_value);
						errors++;
					end
					if (entry_count !== want.count) begin
						$error("entry_count: expected %0d, actual %0d", want.count, entry_count);
						errors++;
					end
					if (top_value !== want.top) begin
						$error("top_value: expected %0d, actual %0d", want.top, top_value);
						errors++;
					end
					if (top_valid !== want.top_valid) begin
						$error("top_valid: expected %0d, actual %0d", want.top_valid, top_valid);
						errors++;
					end
				end
			end
			taken = start && !busy;
			if (taken) begin
				awaited_results.push_back(heap_apply(operation, new_value));
				n_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int k;

		// Directed: remove on an empty heap, extremes, equal keys, then drain
		// past empty again.
		plan(OP_REMOVE, data_t'(32'h1234_5678));
		plan(OP_INSERT, data_t'(0));
		plan(OP_INSERT, data_t'(32'h7fff_ffff));
		plan(OP_INSERT, data_t'(32'h8000_0000));
		plan(OP_INSERT, data_t'(-1));
		plan(OP_INSERT, data_t'(1));
		plan(OP_INSERT, data_t'(5));
		plan(OP_INSERT, data_t'(5));
		plan(OP_INSERT, data_t'(5));
		plan(OP_INSERT, data_t'(32'h8000_0000));
		plan(OP_INSERT, data_t'(32'h7fff_ffff));
		plan(OP_INSERT, data_t'(3));
		plan(OP_INSERT, data_t'(4));
		for (k = 0; k < 12; k++)
			plan(OP_REMOVE, data_t'(32'hffff_ffff));
		plan(OP_REMOVE, data_t'(0));

		// Random phases: mixed traffic, fill past full, bounce at full without
		// idling, drain past empty, mixed again, then a tail without idling.
		plan_mixed(150, 65);
		while (plan_count < CAPACITY)
			plan(OP_INSERT, pick_value());
		for (k = 0; k < 4; k++)
			plan(OP_INSERT, pick_value());
		gaps_on = 1'b0;
		plan_mixed(60, 50);
		gaps_on = 1'b1;
		while (plan_count > 0)
			plan(OP_REMOVE, data_t'($urandom));
		for (k = 0; k < 3; k++)
			plan(OP_REMOVE, data_t'($urandom));
		plan_mixed(100, 45);
		gaps_on = 1'b0;
		plan_mixed(100, 55);
		total_cmds = pending_cmds.size();

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		while (n_accepted != total_cmds || awaited_results.size() != 0)
			@(negedge clk);
		// any stray done in this window is caught by the monitor
		repeat (DRAIN_WAIT) @(negedge clk);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
